// ===== src/tcw_pkg.sv =====
// Shared constants, codes and types of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int CELL_W     = 16;
   localparam int POS_W      = 10;
   localparam int ROW_CELLS  = 80;
   localparam int TAB_STEP   = 8;
   localparam int DIGIT_W    = 4;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_CHARS  = 10;
   localparam int BCD_W      = DIGIT_W * DEC_DIGITS;
   localparam int CNT_W      = $clog2(HEX_CHARS + 1);
   localparam int BITCNT_W   = $clog2(VALUE_W + 1);

   typedef enum logic [1:0] {
      FUNC_CHAR = 2'd0,
      FUNC_DEC  = 2'd1,
      FUNC_HEX  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   localparam logic [CHAR_W-1:0] CH_TAB        = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X          = 8'h78;
   localparam logic [CHAR_W-1:0] CH_HEX_ALPHA  = 8'd55;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;
   localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN  = 4'd5;
   localparam logic [DIGIT_W-1:0] BCD_ADJ      = 4'd3;

endpackage

// ===== src/tcw_if.sv =====
// Request and response channel interfaces of the text console writer.
`timescale 1ns / 1ps
interface tcw_req_if
   import tcw_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [VALUE_W-1:0] value;
   logic [COLOR_W-1:0] color;

   modport source (output valid, func, value, color, input ready);
   modport sink   (input valid, func, value, color, output ready);
endinterface

interface tcw_rsp_if
   import tcw_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               write_enable;
   logic [CELL_W-1:0]  cell_index;
   logic [CHAR_W-1:0]  char_code;
   logic [COLOR_W-1:0] cell_color;
   logic [CELL_W-1:0]  cursor_index;
   logic               last;

   modport source (output valid, write_enable, cell_index, char_code, cell_color,
                   cursor_index, last, input ready);
   modport sink   (input valid, write_enable, cell_index, char_code, cell_color,
                   cursor_index, last, output ready);
endinterface

// ===== src/text_console_writer.sv =====
// Text console writer: top level, cursor tracking and character emission.
// Character and hex requests go straight to emission; responses then follow one a cycle
//   while the receiver is ready. Decimal: accept, bit-serial BCD conversion, leading-zero
//   skip, then one response per digit.
// The next request is taken once the last response is registered. Synchronous reset
//   clears the state, the cursor and the response valid flag.
`timescale 1ns / 1ps
module text_console_writer
   import tcw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_type;
   typedef enum logic [1:0] {MODE_CHAR, MODE_DEC, MODE_HEX} mode_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [POS_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [BCD_W-1:0]   digits_ff, digits_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         pre_ff, pre_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_we_ff, rsp_we_in;
   logic [CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic [CELL_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_accept, rsp_load, bcd_start, bcd_done;
   logic [BCD_W-1:0]   bcd;
   logic [DIGIT_W-1:0] nib;
   logic [CHAR_W-1:0]  emit_char;
   logic [POS_W-1:0]   row_nx, col_nx;
   logic               we_nx;

   tcw_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .value (req_chan.value),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign bcd_start      = req_accept && (func_type'(req_chan.func) == FUNC_DEC);
   assign rsp_load       = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign nib            = digits_ff[BCD_W-1 -: DIGIT_W];

   always_comb begin
      unique case (mode_ff)
         MODE_CHAR: emit_char = char_ff;
         MODE_DEC:  emit_char = CH_ZERO + CHAR_W'(nib);
         MODE_HEX: begin
            if (pre_ff == 2'd2) begin
               emit_char = CH_ZERO;
            end else if (pre_ff == 2'd1) begin
               emit_char = CH_X;
            end else if (nib < DIGIT_TEN) begin
               emit_char = CH_ZERO + CHAR_W'(nib);
            end else begin
               emit_char = CH_HEX_ALPHA + CHAR_W'(nib);
            end
         end
         default:   emit_char = char_ff;
      endcase
   end

   always_comb begin
      row_nx = row_ff;
      col_nx = col_ff;
      we_nx  = 1'b0;
      if (emit_char == CH_NEWLINE) begin
         row_nx = row_ff + 1'b1;
         col_nx = '0;
      end else if (emit_char == CH_TAB) begin
         col_nx = col_ff + POS_W'(TAB_STEP);
      end else begin
         we_nx  = 1'b1;
         col_nx = col_ff + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      digits_in     = digits_ff;
      cnt_in        = cnt_ff;
      pre_in        = pre_ff;
      char_in       = char_ff;
      color_in      = color_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_we_in     = rsp_we_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               color_in = req_chan.color;
               char_in  = req_chan.value[CHAR_W-1:0];
               pre_in   = '0;
               case (func_type'(req_chan.func))
                  FUNC_CHAR: begin
                     mode_in  = MODE_CHAR;
                     cnt_in   = CNT_W'(1);
                     state_in = ST_EMIT;
                  end
                  FUNC_DEC: begin
                     mode_in  = MODE_DEC;
                     state_in = ST_CONV;
                  end
                  FUNC_HEX: begin
                     mode_in   = MODE_HEX;
                     digits_in = {req_chan.value, (BCD_W-VALUE_W)'(0)};
                     cnt_in    = CNT_W'(HEX_CHARS);
                     pre_in    = 2'd2;
                     state_in  = ST_EMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            if (bcd_done) begin
               digits_in = bcd;
               cnt_in    = CNT_W'(DEC_DIGITS);
               state_in  = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (nib == '0 && cnt_ff > CNT_W'(1)) begin
               digits_in = {digits_ff[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
               cnt_in    = cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_we_in     = we_nx;
               rsp_cell_in   = we_nx ? CELL_W'(row_ff) * CELL_W'(ROW_CELLS) + CELL_W'(col_ff)
                                     : '0;
               rsp_char_in   = we_nx ? emit_char : '0;
               rsp_color_in  = we_nx ? color_ff : '0;
               rsp_cursor_in = CELL_W'(row_nx) * CELL_W'(ROW_CELLS) + CELL_W'(col_nx);
               rsp_last_in   = (cnt_ff == CNT_W'(1));
               row_in        = row_nx;
               col_in        = col_nx;
               cnt_in        = cnt_ff - 1'b1;
               if (pre_ff != 2'd0) begin
                  pre_in = pre_ff - 1'b1;
               end else begin
                  digits_in = {digits_ff[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
               end
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      digits_ff     <= digits_in;
      pre_ff        <= pre_in;
      char_ff       <= char_in;
      color_ff      <= color_in;
      rsp_we_ff     <= rsp_we_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.write_enable = rsp_we_ff;
   assign rsp_chan.cell_index   = rsp_cell_ff;
   assign rsp_chan.char_code    = rsp_char_ff;
   assign rsp_chan.cell_color   = rsp_color_ff;
   assign rsp_chan.cursor_index = rsp_cursor_ff;
   assign rsp_chan.last         = rsp_last_ff;

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> state_ff == ST_CONV)
      else $error("converter finished outside conversion");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SKIP) |-> cnt_ff != '0)
      else $error("no characters left while emitting");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && cnt_ff == CNT_W'(1)) |=> state_ff == ST_IDLE && rsp_last_ff)
      else $error("final response did not end the request");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("response raised outside emission");

endmodule

// ===== src/tcw_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`timescale 1ns / 1ps
module tcw_bcd
   import tcw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] value,
   output logic               done,
   output logic [BCD_W-1:0]   bcd
);

   logic [VALUE_W-1:0]  shift_ff, shift_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BITCNT_W-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [BCD_W-1:0]    adj;

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = value;
         bcd_in   = '0;
         count_in = BITCNT_W'(VALUE_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {adj[BCD_W-2:0], shift_ff[VALUE_W-1]};
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == BITCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== tb/text_console_writer_test.sv =====
// Testbench of the text console writer: directed and random requests against a cursor model.
`timescale 1ns / 1ps
module text_console_writer_test;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_SETTLE = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 31;

   typedef struct {
      logic               write_enable;
      logic [CELL_W-1:0]  cell_index;
      logic [CHAR_W-1:0]  char_code;
      logic [COLOR_W-1:0] cell_color;
      logic [CELL_W-1:0]  cursor_index;
      logic               last;
   } cell_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // cursor model
   logic [POS_W-1:0] cursor_row = '0;
   logic [POS_W-1:0] cursor_col = '0;
   cell_update_type  pending_updates[$];

   int  mismatches    = 0;
   int  requests_sent = 0;
   int  updates_seen  = 0;
   int  func_count[4] = '{default: 0};
   int  cycle_count   = 0;
   int  hold_requests = 0;
   bit  sender_idle_on = 1'b1;
   bit  rsp_idle_on    = 1'b1;

   function automatic logic [CELL_W-1:0] cursor_cell();
      return CELL_W'(cursor_row * ROW_CELLS + cursor_col);
   endfunction

   function automatic void print_char(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
                                      logic is_last);
      cell_update_type u;
      u = '{write_enable: 1'b0, cell_index: '0, char_code: '0, cell_color: '0,
            cursor_index: '0, last: 1'b0};
      if (ch == CH_NEWLINE) begin
         cursor_col = '0;
         cursor_row = cursor_row + 1'b1;
      end else if (ch == CH_TAB) begin
         cursor_col = cursor_col + POS_W'(TAB_STEP);
      end else begin
         u.write_enable = 1'b1;
         u.cell_index   = cursor_cell();
         u.char_code    = ch;
         u.cell_color   = color;
         cursor_col     = cursor_col + 1'b1;
      end
      u.cursor_index = cursor_cell();
      u.last         = is_last;
      pending_updates.push_back(u);
   endfunction

   function automatic void predict_request(func_type f, logic [VALUE_W-1:0] v,
                                           logic [COLOR_W-1:0] color);
      logic [DIGIT_W-1:0] digits[DEC_DIGITS];
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] nib;
      int                 n;
      int                 i;
      case (f)
         FUNC_CHAR: begin
            print_char(v[CHAR_W-1:0], color, 1'b1);
         end
         FUNC_DEC: begin
            rest = v;
            n    = 0;
            do begin
               digits[n] = DIGIT_W'(rest % 10);
               rest      = rest / 10;
               n++;
            end while (rest != 0);
            for (i = n - 1; i >= 0; i--)
               print_char(CH_ZERO + digits[i], color, i == 0);
         end
         FUNC_HEX: begin
            print_char(CH_ZERO, color, 1'b0);
            print_char(CH_X, color, 1'b0);
            for (i = 7; i >= 0; i--) begin
               nib = v[DIGIT_W*i +: DIGIT_W];
               print_char(nib < DIGIT_TEN ? CH_ZERO + nib : CH_HEX_ALPHA + nib, color, i == 0);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(func_type f, logic [VALUE_W-1:0] v, logic [COLOR_W-1:0] c);
      while (sender_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= f;
      req_bus.value <= v;
      req_bus.color <= c;
      do @(posedge clock); while (!req_bus.ready);
      predict_request(f, v, c);
      requests_sent++;
      func_count[f]++;
   endtask

   function automatic logic [VALUE_W-1:0] random_decimal();
      longint acc;
      acc = 0;
      case ($urandom_range(2))
         0: return $urandom >> $urandom_range(31);
         1: begin
            repeat ($urandom_range(1, DEC_DIGITS))
               acc = acc * 10 + ($urandom_range(1) ? 0 : $urandom_range(9));
            return acc[VALUE_W-1:0];
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_request();
      int                 pick;
      logic [VALUE_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 35) begin
         v = $urandom;
         if ($urandom_range(9) < 2)
            v[CHAR_W-1:0] = $urandom_range(1) ? CH_NEWLINE : CH_TAB;
         send_request(FUNC_CHAR, v, COLOR_W'($urandom));
      end else if (pick < 65) begin
         send_request(FUNC_DEC, random_decimal(), COLOR_W'($urandom));
      end else if (pick < 92) begin
         send_request(FUNC_HEX, $urandom, COLOR_W'($urandom));
      end else begin
         send_request(FUNC_NONE, $urandom, COLOR_W'($urandom));
      end
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_updates.size() != 0);
   endtask

   task automatic test_characters();
      send_request(FUNC_CHAR, 32'h0000_0041, 8'h00);
      send_request(FUNC_CHAR, 32'h0000_00FF, 8'hFF);
      send_request(FUNC_CHAR, 32'hFFFF_FF20, 8'h5A);
      send_request(FUNC_CHAR, 32'h0000_0000, 8'hA5);
      send_request(FUNC_CHAR, {24'h0, CH_NEWLINE}, 8'h17);
      send_request(FUNC_CHAR, {24'hFFFFFF, CH_TAB}, 8'hE8);
      send_request(FUNC_CHAR, {24'hABCD00, CH_NEWLINE}, 8'h00);
      send_request(FUNC_NONE, 32'hFFFF_FFFF, 8'hFF);
      send_request(FUNC_NONE, 32'h0000_0000, 8'h00);
   endtask

   task automatic test_decimal();
      send_request(FUNC_DEC, 32'd0, 8'h07);
      send_request(FUNC_DEC, 32'hFFFF_FFFF, 8'h1F);
      send_request(FUNC_DEC, 32'd1000000007, 8'h2E);
      send_request(FUNC_DEC, 32'd10, 8'h70);
      send_request(FUNC_DEC, 32'd5, 8'h81);
      send_request(FUNC_DEC, 32'd100, 8'hC3);
   endtask

   task automatic test_hex();
      send_request(FUNC_HEX, 32'h0000_0000, 8'h0F);
      send_request(FUNC_HEX, 32'hFFFF_FFFF, 8'hF0);
      send_request(FUNC_HEX, 32'h0123_ABCD, 8'h3C);
      send_request(FUNC_HEX, 32'h89EF_4567, 8'hC3);
   endtask

   task automatic test_random_mix();
      repeat (45) send_random_request();
   endtask

   task automatic test_back_to_back();
      sender_idle_on = 1'b0;
      rsp_idle_on    = 1'b0;
      repeat (16) send_random_request();
      sender_idle_on = 1'b1;
      rsp_idle_on    = 1'b1;
   endtask

   // receiver holds off while hex requests keep coming
   task automatic test_output_backpressure();
      hold_requests++;
      repeat (10) send_request(FUNC_HEX, $urandom, COLOR_W'($urandom));
      wait_drain();
   endtask

   task automatic test_pause_then_resume();
      repeat (5) send_random_request();
      wait_drain();
      repeat (5) send_random_request();
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : response_check
      cell_update_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         updates_seen++;
         if (pending_updates.size() == 0) begin
            $error("response with no pending request");
            mismatches++;
         end else begin
            want = pending_updates.pop_front();
            check_field("write_enable", want.write_enable, rsp_bus.write_enable);
            check_field("cell_index", want.cell_index, rsp_bus.cell_index);
            check_field("char_code", want.char_code, rsp_bus.char_code);
            check_field("cell_color", want.cell_color, rsp_bus.cell_color);
            check_field("cursor_index", want.cursor_index, rsp_bus.cursor_index);
            check_field("last", want.last, rsp_bus.last);
         end
      end
   end

   always @(posedge clock) begin : response_ready
      int holds_done;
      int hold_left;
      if (hold_left == 0 && holds_done != hold_requests) begin
         hold_left  = HOLD_CYCLES;
         holds_done = hold_requests;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !(rsp_idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d updates pending", cycle_count,
                pending_updates.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func  = FUNC_CHAR;
      req_bus.value = '0;
      req_bus.color = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_characters();
      test_decimal();
      test_hex();
      test_random_mix();
      test_back_to_back();
      test_output_backpressure();
      test_pause_then_resume();

      wait_drain();
      repeat (DRAIN_SETTLE) @(posedge clock);

      $display("Sent %0d requests (%0d char, %0d decimal, %0d hex, %0d unused), %0d updates",
               requests_sent, func_count[FUNC_CHAR], func_count[FUNC_DEC],
               func_count[FUNC_HEX], func_count[FUNC_NONE], updates_seen);
      $display("Covered cursor moves, leading and inner zeros, a long output hold-off, "
               , "back-to-back traffic and a full drain");
      if (mismatches == 0 && pending_updates.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== text_console_writer.f =====
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_bcd.sv
src/text_console_writer.sv
tb/text_console_writer_test.sv
